// ===== design/hgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Height grid cell decoder package
// Shared payload types, register indexes, limits and float32 helpers.
// ----------------------------------------------------------------------------
package hgcd_pkg;

    localparam int MAX_CELLS = 65536;
    localparam int MAX_RUN   = 64;
    localparam int CNT_W     = 17;
    localparam int RUN_W     = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CELL_FORMAT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODING_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_BITS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CELLS   = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [31:0]      cell_word;
        logic [RUN_W-1:0] run_count;
        logic             final_item;
    } in_item_t;

    typedef struct packed {
        logic [31:0] height_bits;
        logic        cell_valid;
        logic        run_last;
        logic [1:0]  status;
    } out_item_t;

    // queue entry from front to back
    typedef struct packed {
        logic [31:0]      word;
        logic             scaled;
        logic [RUN_W-1:0] count;
        logic             final_item;
        logic [CNT_W-1:0] expect_cells;
    } job_t;

    typedef struct packed {
        logic               sign;
        logic signed [10:0] exp;
        logic [47:0]        mant;
        logic               zero;
        logic               inf;
        logic               nan;
    } fprod_t;

    // int16 to float32, exact
    function automatic logic [31:0] int16_to_f32(input logic [15:0] v);
        logic        s;
        logic [15:0] m;
        logic [4:0]  lz;
        logic [15:0] n;
        logic [31:0] r;
        s  = v[15];
        m  = s ? (~v + 16'd1) : v;
        lz = 5'd0;
        for (int i = 15; i >= 0; i--) begin
            if (m[i] && lz == 5'd0) lz = 5'(16 - i);
        end
        if (m == 16'd0) begin
            r = 32'd0;
        end else begin
            n = m << (lz - 5'd1);
            r = {s, 8'(127 + 16 - int'(lz)), n[14:0], 8'd0};
        end
        return r;
    endfunction

    // round a normalized magnitude with hidden bit at mant[47] and sticky
    function automatic logic [31:0] f32_pack(input logic s, input logic signed [10:0] e,
                                             input logic [47:0] mant);
        logic [49:0] m;
        logic signed [10:0] ee;
        logic [5:0]  sh;
        logic [24:0] q;
        logic        g;
        logic        st;
        logic [31:0] r;
        m  = {mant, 2'b00};
        ee = e;
        if (ee < 11'sd1) begin
            sh = (11'sd1 - ee > 11'sd40) ? 6'd40 : 6'(11'sd1 - ee);
            st = 1'b0;
            for (int i = 0; i < 50; i++) begin
                if (i < int'(sh) && m[i]) st = 1'b1;
            end
            m  = (m >> sh) | {49'd0, st};
            ee = 11'sd0;
        end
        q  = {1'b0, m[49:26]};
        g  = m[25];
        st = |m[24:0];
        if (g && (st || q[0])) q = q + 25'd1;
        if (q[24]) begin
            q  = q >> 1;
            ee = ee + 11'sd1;
        end else if (ee == 11'sd0 && q[23]) begin
            ee = 11'sd1;
        end
        if (ee >= 11'sd255) r = {s, 8'hFF, 23'd0};
        else                r = {s, ee[7:0], q[22:0]};
        return r;
    endfunction

    // stage 1 of multiply: unpack and multiply mantissas
    function automatic fprod_t f32_mul_raw(input logic [31:0] a, input logic [31:0] b);
        fprod_t p;
        logic [23:0] ma;
        logic [23:0] mb;
        logic signed [10:0] e;
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        p.sign = a[31] ^ b[31];
        p.nan  = (&a[30:23] && |a[22:0]) || (&b[30:23] && |b[22:0]) ||
                 (&a[30:23] && b[30:0] == 31'd0) || (&b[30:23] && a[30:0] == 31'd0);
        p.inf  = &a[30:23] || &b[30:23];
        p.zero = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
        e = 11'(a[30:23] == 8'd0 ? 8'd1 : a[30:23]) + 11'(b[30:23] == 8'd0 ? 8'd1 : b[30:23])
            - 11'sd127;
        p.mant = ma * mb;
        p.exp  = e;
        return p;
    endfunction

endpackage

// ===== design/height_grid_cell_decoder.sv =====
// ----------------------------------------------------------------------------
// Height grid cell decoder
// Expands raw or run-length cell items into float32 heights with grid checks.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer when
//  in       | in_valid, in_ready, in_item      | in_valid && in_ready
//  out      | out_valid, out_ready, out_item   | out_valid && out_ready
//  cfg      | cfg_we, cfg_idx, cfg_data        | cfg_we
//
//  A float32 cell goes straight from idle to emit in the back end; an int16
//  cell first passes through the multiply, product rounding and add steps.
//  In a run, one result leaves per cycle while out_ready holds; the result
//  register and the one-entry job queue let the front take the next item
//  meanwhile. Reset restores register defaults and clears the cell counter.
module height_grid_cell_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hgcd_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hgcd_pkg::out_item_t            out_item,
    input  logic                           cfg_we,
    input  logic [hgcd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [hgcd_pkg::CFG_DAT_W-1:0] cfg_data
);

    logic           job_valid;
    logic           job_ready;
    hgcd_pkg::job_t job;
    logic [31:0]    scale_bits;
    logic [31:0]    offset_bits;

    hgcd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .scale_bits  (scale_bits),
        .offset_bits (offset_bits),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job)
    );

    hgcd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .scale_bits  (scale_bits),
        .offset_bits (offset_bits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item)
    );

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.status <= hgcd_pkg::ST_SHORT)
        else $error("status code out of range");

    a_status_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.cell_valid) |-> out_item.run_last)
        else $error("status-only result without run_last");

    a_status_only_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.cell_valid) |-> out_item.height_bits == 32'd0)
        else $error("status-only result carries height");

endmodule

// ===== design/hgcd_front.sv =====
// ----------------------------------------------------------------------------
// Height grid cell decoder front end
// Accepts input items, resolves count and cell kind, and pushes jobs.
// ----------------------------------------------------------------------------
module hgcd_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  hgcd_pkg::in_item_t       in_item,
    input  logic                     cfg_we,
    input  logic [hgcd_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [hgcd_pkg::CFG_DAT_W-1:0] cfg_data,
    output logic [31:0]              scale_bits,
    output logic [31:0]              offset_bits,
    output logic                     job_valid,
    input  logic                     job_ready,
    output hgcd_pkg::job_t           job
);

    logic                         cell_format_reg;
    logic                         encoding_mode_reg;
    logic [31:0]                  scale_reg;
    logic [31:0]                  offset_reg;
    logic [hgcd_pkg::CNT_W-1:0]   total_reg;
    logic                         full_reg;
    hgcd_pkg::job_t               job_reg;
    hgcd_pkg::job_t               job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_format_reg   <= 1'b0;
            encoding_mode_reg <= 1'b0;
            scale_reg         <= 32'h3F80_0000;
            offset_reg        <= 32'd0;
            total_reg         <= hgcd_pkg::CNT_W'(hgcd_pkg::MAX_CELLS);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                hgcd_pkg::REG_CELL_FORMAT:   cell_format_reg   <= cfg_data[0];
                hgcd_pkg::REG_ENCODING_MODE: encoding_mode_reg <= cfg_data[0];
                hgcd_pkg::REG_SCALE_BITS:    scale_reg         <= cfg_data;
                hgcd_pkg::REG_OFFSET_BITS:   offset_reg        <= cfg_data;
                hgcd_pkg::REG_TOTAL_CELLS:   total_reg         <= cfg_data[hgcd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        job_next.word       = in_item.cell_word;
        job_next.scaled     = cell_format_reg;
        job_next.final_item = in_item.final_item;
        if (!encoding_mode_reg)
            job_next.count = hgcd_pkg::RUN_W'(1);
        else if (in_item.run_count > hgcd_pkg::RUN_W'(hgcd_pkg::MAX_RUN))
            job_next.count = hgcd_pkg::RUN_W'(hgcd_pkg::MAX_RUN);
        else
            job_next.count = in_item.run_count;
        if (total_reg > hgcd_pkg::CNT_W'(hgcd_pkg::MAX_CELLS))
            job_next.expect_cells = hgcd_pkg::CNT_W'(hgcd_pkg::MAX_CELLS);
        else
            job_next.expect_cells = total_reg;
    end

    assign in_ready = !full_reg || job_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (in_valid && in_ready)
            full_reg <= 1'b1;
        else if (job_ready)
            full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            job_reg <= job_next;
    end

    assign job_valid   = full_reg;
    assign job         = job_reg;
    assign scale_bits  = scale_reg;
    assign offset_bits = offset_reg;

endmodule

// ===== design/hgcd_back.sv =====
// ----------------------------------------------------------------------------
// Height grid cell decoder back end
// Decodes a cell (multiply-add if scaled int16) and emits its run.
// ----------------------------------------------------------------------------
module hgcd_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   job_valid,
    output logic                   job_ready,
    input  hgcd_pkg::job_t         job,
    input  logic [31:0]            scale_bits,
    input  logic [31:0]            offset_bits,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hgcd_pkg::out_item_t    out_item
);

    typedef enum logic [2:0] { S_IDLE, S_MUL, S_RND, S_ADD, S_EMIT } state_t;

    state_t                       state_reg;
    hgcd_pkg::job_t               job_reg;
    logic [31:0]                  a_reg;
    logic [31:0]                  height_reg;
    hgcd_pkg::fprod_t             prod_reg;
    logic [hgcd_pkg::RUN_W-1:0]   left_reg;
    logic [hgcd_pkg::CNT_W-1:0]   cnt_reg;
    logic                         ovf_reg;
    logic                         out_valid_reg;
    hgcd_pkg::out_item_t          out_reg;

    logic [31:0]                  prod_bits;
    logic [31:0]                  sum_bits;
    logic                         excess;
    logic                         last;
    logic [hgcd_pkg::CNT_W-1:0]   cnt_inc;
    logic                         out_free;
    logic                         emit;

    // round the product
    always_comb
    begin
        logic [47:0]        m;
        logic signed [10:0] e;
        logic [5:0]         sh;
        logic               hit;
        m   = prod_reg.mant;
        e   = prod_reg.exp + 11'sd1;
        sh  = 6'd0;
        hit = 1'b0;
        for (int i = 47; i >= 0; i--) begin
            if (m[i] && !hit) begin
                sh  = 6'(47 - i);
                hit = 1'b1;
            end
        end
        m = m << sh;
        e = e - 11'(sh);
        if (prod_reg.nan)
            prod_bits = (&scale_bits[30:23] && |scale_bits[22:0]) ?
                        (scale_bits | 32'h0040_0000) : 32'hFFC0_0000;
        else if (prod_reg.inf)  prod_bits = {prod_reg.sign, 8'hFF, 23'd0};
        else if (prod_reg.zero || m == 48'd0) prod_bits = {prod_reg.sign, 31'd0};
        else                    prod_bits = hgcd_pkg::f32_pack(prod_reg.sign, e, m);
    end

    // float32 add of a_reg and offset
    always_comb
    begin
        logic [31:0] x;
        logic [31:0] y;
        logic [7:0]  ex;
        logic [7:0]  ey;
        logic [7:0]  d;
        logic [50:0] mx;
        logic [50:0] my;
        logic [50:0] ms;
        logic        st;
        logic signed [10:0] e;
        logic [5:0]  lz;
        logic [47:0] nm;
        if (a_reg[30:0] >= offset_bits[30:0]) begin x = a_reg; y = offset_bits; end
        else begin x = offset_bits; y = a_reg; end
        ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
        ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
        d  = ex - ey;
        mx = {1'b0, |x[30:23], x[22:0], 26'd0};
        my = {1'b0, |y[30:23], y[22:0], 26'd0};
        st = 1'b0;
        if (d > 8'd50) begin
            st = |my;
            my = 51'd0;
        end else begin
            for (int i = 0; i < 51; i++) begin
                if (i < int'(d) && my[i]) st = 1'b1;
            end
            my = my >> d;
        end
        my[0] = my[0] | st;
        if (x[31] == y[31]) ms = mx + my;
        else                ms = mx - my;
        lz = 6'd0;
        for (int i = 50; i >= 0; i--) begin
            if (ms[i] && lz == 6'd0) lz = 6'(51 - i);
        end
        e  = 11'(ex) + 11'sd2 - 11'(lz);
        nm = 48'(({ms, 1'b0} << (lz - 6'd1)) >> 4);
        nm[0] = nm[0] | |(({ms, 1'b0} << (lz - 6'd1)) & 52'hF);
        if (&a_reg[30:23] && |a_reg[22:0])     sum_bits = a_reg | 32'h0040_0000;
        else if (&offset_bits[30:23] && |offset_bits[22:0])
            sum_bits = offset_bits | 32'h0040_0000;
        else if (&x[30:23] && &y[30:23] && x[31] != y[31]) sum_bits = 32'hFFC0_0000;
        else if (&x[30:23])                    sum_bits = x;
        else if (ms == 51'd0)
            sum_bits = {x[31] & y[31], 31'd0};
        else                                   sum_bits = hgcd_pkg::f32_pack(x[31], e, nm);
    end

    assign last     = (left_reg == hgcd_pkg::RUN_W'(1));
    assign excess   = cnt_reg >= job_reg.expect_cells;
    assign cnt_inc  = (cnt_reg != hgcd_pkg::COUNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign job_ready = (state_reg == S_IDLE) && out_free;
    assign emit     = (state_reg == S_EMIT) && out_free &&
                      ((left_reg != '0) || job_reg.final_item);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && job_ready)
                    begin
                        job_reg  <= job;
                        left_reg <= job.count;
                        a_reg    <= hgcd_pkg::int16_to_f32(job.word[15:0]);
                        if (job.scaled)
                            state_reg <= S_MUL;
                        else
                        begin
                            height_reg <= job.word;
                            state_reg  <= S_EMIT;
                        end
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= hgcd_pkg::f32_mul_raw(a_reg, scale_bits);
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    a_reg     <= prod_bits;
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    height_reg <= sum_bits;
                    state_reg  <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        if (left_reg == '0)
                        begin
                            if (job_reg.final_item)
                            begin
                                out_reg.height_bits <= 32'd0;
                                out_reg.cell_valid  <= 1'b0;
                                out_reg.run_last    <= 1'b1;
                                out_reg.status <= (cnt_reg < job_reg.expect_cells) ?
                                    hgcd_pkg::ST_SHORT :
                                    (ovf_reg ? hgcd_pkg::ST_OVER : hgcd_pkg::ST_OK);
                                cnt_reg <= '0;
                                ovf_reg <= 1'b0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_reg.height_bits <= height_reg;
                            out_reg.cell_valid  <= 1'b1;
                            out_reg.run_last    <= last;
                            out_reg.status <= (last && job_reg.final_item) ?
                                ((cnt_inc < job_reg.expect_cells) ? hgcd_pkg::ST_SHORT :
                                 ((ovf_reg || excess) ? hgcd_pkg::ST_OVER
                                                      : hgcd_pkg::ST_OK)) :
                                (excess ? hgcd_pkg::ST_OVER : hgcd_pkg::ST_OK);
                            left_reg <= left_reg - 1'b1;
                            if (last && job_reg.final_item)
                            begin
                                cnt_reg <= '0;
                                ovf_reg <= 1'b0;
                            end
                            else
                            begin
                                cnt_reg <= cnt_inc;
                                ovf_reg <= ovf_reg | excess;
                            end
                            if (last)
                                state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Height grid cell decoder testbench
// Drives raw and run-length cell items through several register settings,
// predicts every float32 height and grid status, and checks each result
// transfer in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        hgcd_pkg::in_item_t item;
        bit                 drain;
    } pending_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    hgcd_pkg::in_item_t             in_item = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    hgcd_pkg::out_item_t            out_item;
    logic                           cfg_we = 1'b0;
    logic [hgcd_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
    logic [hgcd_pkg::CFG_DAT_W-1:0] cfg_data = '0;

    pending_t            pending_items[$];
    hgcd_pkg::out_item_t heights_due[$];
    pending_t            next_p;

    logic                       fmt_scaled;
    logic                       run_mode;
    logic [31:0]                scale_f;
    logic [31:0]                offset_f;
    logic [hgcd_pkg::CNT_W-1:0] grid_total;
    logic [hgcd_pkg::CNT_W-1:0] cells_done;
    logic                       over_seen;

    int errors;
    int items_sent;
    int results_seen;
    int grids_closed;
    int cycle;
    int stall_cycles;

    height_grid_cell_decoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit go_idle();
        return (cycle < 600 || cycle >= 1200) && $urandom_range(99) < 13;
    endfunction

    function automatic bit is_nan(logic [31:0] b);
        return &b[30:23] && |b[22:0];
    endfunction

    function automatic real f32_value(logic [31:0] b);
        real r;
        if (&b[30:23])
            r = $bitstoreal({b[31], 11'h7FF, 52'd0});
        else if (b[30:23] == 8'd0) begin
            if (b[22:0] == 23'd0)
                r = $bitstoreal({b[31], 63'd0});
            else begin
                r = real'(b[22:0]) * $bitstoreal({1'b0, 11'(1023 - 149), 52'd0});
                if (b[31])
                    r = -r;
            end
        end
        else
            r = $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'd0});
        return r;
    endfunction

    // round to nearest even into float32
    function automatic logic [31:0] f32_round(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        int          fe;
        int          sh;
        bit          guard;
        bit          sticky;
        longint      mag;
        d = $realtobits(r);
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        if (d[62:52] == 11'h7FF)
            return {d[63], 8'hFF, 23'd0};
        fe  = int'(d[62:52]) - 1023 + 127;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 60)
            sh = 60;
        q      = sig >> sh;
        guard  = sig[sh-1];
        sticky = |(sig & ((64'd1 << (sh - 1)) - 64'd1));
        if (guard && (sticky || q[0]))
            q = q + 64'd1;
        mag = (fe >= 1) ? (longint'(fe - 1) << 23) : 0;
        mag = mag + longint'(q);
        if (mag >= 64'h7F800000)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] cell_height(logic [31:0] word);
        logic [31:0] prod;
        if (!fmt_scaled)
            return word;
        if (is_nan(scale_f))
            prod = scale_f | 32'h0040_0000;
        else if (&scale_f[30:23] && word[15:0] == 16'd0)
            prod = 32'hFFC0_0000;
        else
            prod = f32_round(real'($signed(word[15:0])) * f32_value(scale_f));
        if (is_nan(prod))
            return prod | 32'h0040_0000;
        if (is_nan(offset_f))
            return offset_f | 32'h0040_0000;
        if (&prod[30:23] && &offset_f[30:23] && prod[31] != offset_f[31])
            return 32'hFFC0_0000;
        return f32_round(f32_value(prod) + f32_value(offset_f));
    endfunction

    task automatic predict_cells(hgcd_pkg::in_item_t it);
        logic [hgcd_pkg::CNT_W-1:0] limit;
        logic [31:0]                h;
        int                         count;
        hgcd_pkg::out_item_t        r;
        limit = (grid_total > hgcd_pkg::MAX_CELLS) ?
                hgcd_pkg::CNT_W'(hgcd_pkg::MAX_CELLS) : grid_total;
        count = !run_mode ? 1 :
                (it.run_count > hgcd_pkg::MAX_RUN ? hgcd_pkg::MAX_RUN : int'(it.run_count));
        h = cell_height(it.cell_word);
        for (int i = 0; i < count; i++)
        begin
            r = '{height_bits: h, cell_valid: 1'b1, run_last: (i == count - 1),
                  status: hgcd_pkg::ST_OK};
            if (cells_done >= limit)
            begin
                r.status  = hgcd_pkg::ST_OVER;
                over_seen = 1'b1;
            end
            if (cells_done != hgcd_pkg::COUNT_MAX)
                cells_done++;
            heights_due.insert(heights_due.size(), r);
        end
        if (it.final_item)
        begin
            if (count == 0)
            begin
                r = '{height_bits: 32'd0, cell_valid: 1'b0, run_last: 1'b1,
                      status: hgcd_pkg::ST_OK};
                heights_due.insert(heights_due.size(), r);
            end
            heights_due[$].status = (cells_done < limit) ? hgcd_pkg::ST_SHORT :
                                    (over_seen ? hgcd_pkg::ST_OVER : hgcd_pkg::ST_OK);
            cells_done = '0;
            over_seen  = 1'b0;
            grids_closed++;
        end
    endtask

    task automatic report(string what, hgcd_pkg::out_item_t got, hgcd_pkg::out_item_t want);
        errors++;
        if (errors <= 20)
            $display("mismatch %s at %0t: got %h/%b/%b/%0d want %h/%b/%b/%0d", what, $time,
                     got.height_bits, got.cell_valid, got.run_last, got.status,
                     want.height_bits, want.cell_valid, want.run_last, want.status);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_cells(in_item);
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && !go_idle() &&
                    !(pending_items[0].drain && heights_due.size() > 0))
                begin
                    next_p = pending_items.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= next_p.item;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (heights_due.size() == 0)
                    report("unexpected", out_item, '0);
                else if (out_item !== heights_due[0])
                    report("field", out_item, heights_due.pop_front());
                else
                    void'(heights_due.pop_front());
            end
            out_ready <= !go_idle();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle++;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= 5000)
        begin
            $display("timeout with %0d results outstanding", heights_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic settle();
        while (pending_items.size() > 0 || in_valid || heights_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [hgcd_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            hgcd_pkg::REG_CELL_FORMAT:   fmt_scaled = data[0];
            hgcd_pkg::REG_ENCODING_MODE: run_mode   = data[0];
            hgcd_pkg::REG_SCALE_BITS:    scale_f    = data;
            hgcd_pkg::REG_OFFSET_BITS:   offset_f   = data;
            hgcd_pkg::REG_TOTAL_CELLS:   grid_total = data[hgcd_pkg::CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup(bit fmt, bit mode, logic [31:0] sc, logic [31:0] off,
                         logic [hgcd_pkg::CNT_W-1:0] tot);
        settle();
        write_reg(hgcd_pkg::REG_CELL_FORMAT, 32'(fmt));
        write_reg(hgcd_pkg::REG_ENCODING_MODE, 32'(mode));
        write_reg(hgcd_pkg::REG_SCALE_BITS, sc);
        write_reg(hgcd_pkg::REG_OFFSET_BITS, off);
        write_reg(hgcd_pkg::REG_TOTAL_CELLS, 32'(tot));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_item(logic [31:0] w, int run, bit fin, bit drain = 0);
        pending_t p;
        p.item  = '{cell_word: w, run_count: hgcd_pkg::RUN_W'(run), final_item: fin};
        p.drain = drain;
        pending_items.insert(pending_items.size(), p);
    endtask

    function automatic logic [31:0] pick_float();
        case ($urandom_range(9))
            0: return 32'h3F80_0000;
            1: return 32'h0000_0000;
            2: return 32'h7F7F_FFFF;
            3: return 32'h0000_0001;
            4: return {1'($urandom_range(1)), 8'hFF, 23'd0};
            5: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
            6: return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [hgcd_pkg::CNT_W-1:0] tot;
        int                         run;
        fmt_scaled = 1'b0;
        run_mode   = 1'b0;
        scale_f    = 32'h3F80_0000;
        offset_f   = 32'h0;
        grid_total = hgcd_pkg::CNT_W'(hgcd_pkg::MAX_CELLS);
        cells_done = '0;
        over_seen  = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        grids_closed = 0;
        cycle = 0;
        stall_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: raw float32 pass-through, grid ends short
        queue_item(32'h0000_0000, 127, 0);
        queue_item(32'hFFFF_FFFF, 0, 0);
        queue_item(32'h7FC0_0001, 5, 1);

        // run-length int16 with overflow, empty runs and a saturated run
        setup(1, 1, 32'h3F80_0000, 32'h0, 17'd5);
        queue_item(32'hFFFF_8000, 64, 0, 1);
        queue_item(32'h1234_7FFF, 0, 0);
        queue_item(32'h0000_0001, 127, 0);
        queue_item(32'hABCD_FFFF, 1, 0);
        queue_item(32'h0000_0000, 0, 1);
        queue_item(32'h0000_0003, 5, 1);
        queue_item(32'h0000_0004, 0, 1);

        // zero total: every cell is an excess cell
        setup(0, 0, 32'h4000_0000, 32'hBF80_0000, 17'd0);
        queue_item(32'h4049_0FDB, 0, 0);
        queue_item(32'h8000_0000, 0, 1);

        // oversized total clamps; scale and offset at the extremes
        setup(1, 1, 32'h7F7F_FFFF, 32'hFF80_0000, 17'h1FFFF);
        queue_item(32'h0000_7FFF, 3, 0);
        queue_item(32'h0000_0000, 2, 0);
        queue_item(32'h0000_8000, 1, 1);
        setup(1, 0, 32'h0000_0001, 32'h8000_0001, 17'd2);
        queue_item(32'h0000_0003, 0, 0);
        queue_item(32'h0000_FFFD, 0, 1);
        queue_item(32'hFFFF_0000, 0, 1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(5))
                0: tot = 17'd0;
                1: tot = 17'h1FFFF;
                2: tot = hgcd_pkg::CNT_W'(hgcd_pkg::MAX_CELLS);
                default: tot = hgcd_pkg::CNT_W'($urandom_range(1, 40));
            endcase
            setup(1'($urandom_range(1)), 1'($urandom_range(1)), pick_float(), pick_float(),
                  tot);
            for (int i = 0; i < 28; i++)
            begin
                run = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(8);
                queue_item($urandom, run, $urandom_range(7) == 0 || i == 27,
                           $urandom_range(39) == 0);
            end
        end

        settle();
        repeat (30) @(posedge clk);
        if (heights_due.size() != 0)
            report("missing", '0, heights_due[0]);
        $display("covered %0d items, %0d results, %0d grids over raw and run-length,",
                 items_sent, results_seen, grids_closed);
        $display("float32 and scaled int16 cells, with short and overfull grids");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/hgcd_pkg.sv
design/hgcd_front.sv
design/hgcd_back.sv
design/height_grid_cell_decoder.sv
tb/testbench.sv
